@@ hdl/pli_pkg.sv @@
// pli_pkg: shared types and constants of the positional list unit
// holds opcodes, status codes and the command broadcast to the cell row
// no dependencies
package pli_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int OP_W      = 3;
    localparam int POS_W     = 9;
    localparam int DATA_W    = 32;
    localparam int STAT_W    = 2;

    // request opcodes
    typedef enum logic [OP_W-1:0] {
        OP_APPEND_TAIL = 3'd0,
        OP_REMOVE_TAIL = 3'd1,
        OP_INSERT_HEAD = 3'd2,
        OP_REMOVE_HEAD = 3'd3,
        OP_INSERT_AT   = 3'd4,
        OP_REMOVE_AT   = 3'd5,
        OP_READ        = 3'd6,
        OP_NOP         = 3'd7
    } op_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // what each cell does this cycle
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_REM  = 2'd2,
        CELL_RD   = 2'd3
    } cell_kind_t;

    // command broadcast to every cell in the row
    typedef struct packed {
        cell_kind_t              kind;
        logic [POS_W-1:0]        idx;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

@@ hdl/pli_cell.sv @@
// pli_cell: one entry of the list, shifting with its neighbors
// depends on pli_pkg for the broadcast command type
module pli_cell #(
    parameter int IDX = 0
) (
    input  logic                              aclk,
    input  pli_pkg::cell_cmd_t                cmd,
    input  logic signed [pli_pkg::DATA_W-1:0] below_val,
    input  logic signed [pli_pkg::DATA_W-1:0] above_val,
    output logic signed [pli_pkg::DATA_W-1:0] entry_val,
    output logic signed [pli_pkg::DATA_W-1:0] rd_tap
);

    localparam logic [pli_pkg::POS_W-1:0] MY_IDX = pli_pkg::POS_W'(IDX);

    logic signed [pli_pkg::DATA_W-1:0] entry_reg;
    logic signed [pli_pkg::DATA_W-1:0] entry_next;
    logic                              is_eq;
    logic                              is_ge;

    assign is_eq = (MY_IDX == cmd.idx);
    assign is_ge = (MY_IDX >= cmd.idx);

    // next entry: load at the gap, take from below when opening, from above when closing
    always_comb begin
        entry_next = entry_reg;
        case (cmd.kind)
            pli_pkg::CELL_INS: begin
                if (is_eq) begin
                    entry_next = cmd.value;
                end else if (is_ge) begin
                    entry_next = below_val;
                end
            end
            pli_pkg::CELL_REM: begin
                if (is_ge) begin
                    entry_next = above_val;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    // entry storage, undefined until written
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    // read tap, zero unless this cell is addressed
    assign rd_tap    = (cmd.kind == pli_pkg::CELL_RD && is_eq) ? entry_reg : '0;
    assign entry_val = entry_reg;

endmodule

@@ hdl/positional_list_insert_delete_unit.sv @@
// positional_list_insert_delete_unit: ordered list of signed 32-bit values
// built as a row of pli_cell entries that shift in parallel
// depends on pli_pkg and pli_cell
//
// Usage:
//   s_tdata carries one request: opcode, 1-based position and value. Each
//   request yields exactly one result on m_tdata: status, read value and
//   the entry count after the operation.
//   A request's result is registered in the output register in the cycle
//   after the request is accepted. One request per cycle is taken while the
//   output register is empty or being drained; the whole cell row is updated
//   at the same edge that accepts the request, so the output register is the
//   only thing that sets the rate.
//   When the receiver holds m_tready low, the result stays in the output
//   register and s_tready drops until it is taken.
//   A synchronous active-low aresetn empties the list and drops m_tvalid;
//   s_tready is held low while aresetn is low. The entry storage itself is
//   not cleared, only the count.
module positional_list_insert_delete_unit #(
    parameter int DEPTH = pli_pkg::DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata fields from bit 0: opcode[2:0], position[11:3], value[43:12], zero pad
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata fields from bit 0: status[1:0], read_value[33:2], entry_count[42:34], zero pad
    output logic [47:0] m_tdata
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

    logic                              in_accept;
    pli_pkg::op_t                      req_op;
    logic [pli_pkg::POS_W-1:0]         req_pos;
    logic signed [pli_pkg::DATA_W-1:0] req_val;

    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic [pli_pkg::POS_W-1:0]         count_ext;
    logic                              full;
    logic                              empty;
    logic                              pos_ok;

    pli_pkg::status_t                  status_next;
    pli_pkg::cell_cmd_t                cmd;

    logic signed [pli_pkg::DATA_W-1:0] cell_val [DEPTH];
    logic signed [pli_pkg::DATA_W-1:0] cell_tap [DEPTH];
    logic signed [pli_pkg::DATA_W-1:0] rd_value;

    logic                              out_valid_reg;
    pli_pkg::status_t                  out_status_reg;
    logic signed [pli_pkg::DATA_W-1:0] out_rd_reg;
    logic [CNT_W-1:0]                  out_count_reg;

    // request unpacking
    assign req_op  = pli_pkg::op_t'(s_tdata[2:0]);
    assign req_pos = s_tdata[11:3];
    assign req_val = s_tdata[43:12];

    // no request is taken while reset is held
    assign s_tready  = aresetn && (!out_valid_reg || m_tready);
    assign in_accept = s_tvalid && s_tready;

    // list condition flags
    assign count_ext = pli_pkg::POS_W'(count_reg);
    assign full      = (count_reg == DEPTH_C);
    assign empty     = (count_reg == '0);
    assign pos_ok    = (req_pos != '0) && (req_pos <= count_ext);

    // decode: status, count update and cell row command
    always_comb begin
        status_next = pli_pkg::ST_OK;
        count_next  = count_reg;
        cmd.kind    = pli_pkg::CELL_HOLD;
        cmd.idx     = req_pos - pli_pkg::POS_W'(1);
        cmd.value   = req_val;
        case (req_op)
            pli_pkg::OP_APPEND_TAIL: begin
                if (full) begin
                    status_next = pli_pkg::ST_FULL;
                end else begin
                    cmd.kind   = pli_pkg::CELL_INS;
                    cmd.idx    = count_ext;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            pli_pkg::OP_REMOVE_TAIL: begin
                if (empty) begin
                    status_next = pli_pkg::ST_EMPTY;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            pli_pkg::OP_INSERT_HEAD: begin
                if (full) begin
                    status_next = pli_pkg::ST_FULL;
                end else begin
                    cmd.kind   = pli_pkg::CELL_INS;
                    cmd.idx    = '0;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            pli_pkg::OP_REMOVE_HEAD: begin
                if (empty) begin
                    status_next = pli_pkg::ST_EMPTY;
                end else begin
                    cmd.kind   = pli_pkg::CELL_REM;
                    cmd.idx    = '0;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            pli_pkg::OP_INSERT_AT: begin
                if (full) begin
                    status_next = pli_pkg::ST_FULL;
                end else if (!pos_ok) begin
                    status_next = pli_pkg::ST_RANGE;
                end else begin
                    cmd.kind   = pli_pkg::CELL_INS;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            pli_pkg::OP_REMOVE_AT: begin
                if (empty) begin
                    status_next = pli_pkg::ST_EMPTY;
                end else if (!pos_ok) begin
                    status_next = pli_pkg::ST_RANGE;
                end else begin
                    cmd.kind   = pli_pkg::CELL_REM;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            pli_pkg::OP_READ: begin
                if (empty) begin
                    status_next = pli_pkg::ST_EMPTY;
                end else if (!pos_ok) begin
                    status_next = pli_pkg::ST_RANGE;
                end else begin
                    cmd.kind = pli_pkg::CELL_RD;
                end
            end
            default: begin
                status_next = pli_pkg::ST_OK;
            end
        endcase
        // nothing moves unless the request is taken
        if (!in_accept) begin
            cmd.kind   = pli_pkg::CELL_HOLD;
            count_next = count_reg;
        end
    end

    // row of cells, each linked to its neighbors
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [pli_pkg::DATA_W-1:0] below_v;
        logic signed [pli_pkg::DATA_W-1:0] above_v;
        if (i == 0) begin : g_first
            assign below_v = '0;
        end else begin : g_mid_lo
            assign below_v = cell_val[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign above_v = cell_val[i];
        end else begin : g_mid_hi
            assign above_v = cell_val[i+1];
        end
        pli_cell #(
            .IDX (i)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .below_val (below_v),
            .above_val (above_v),
            .entry_val (cell_val[i]),
            .rd_tap    (cell_tap[i])
        );
    end

    // merge read taps, at most one is nonzero
    always_comb begin
        rd_value = '0;
        for (int k = 0; k < DEPTH; k++) begin
            rd_value = rd_value | cell_tap[k];
        end
    end

    // count and output control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (in_accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            out_status_reg <= status_next;
            out_rd_reg     <= rd_value;
            out_count_reg  <= count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, pli_pkg::POS_W'(out_count_reg), out_rd_reg, out_status_reg};

    // count stays within capacity
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("entry count above capacity");

    // count moves only on a taken request
    a_count_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_accept |=> $stable(count_reg))
        else $error("entry count changed without a request");

    // full status only reported with a full list
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg == pli_pkg::ST_FULL) |-> (out_count_reg == DEPTH_C))
        else $error("full status with room left");

    // empty status only reported with an empty list
    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_status_reg == pli_pkg::ST_EMPTY) |-> (out_count_reg == '0))
        else $error("empty status with entries held");

endmodule

@@ tb/tb_positional_list_insert_delete_unit.sv @@
`timescale 1ns / 1ps
// tb_positional_list_insert_delete_unit: self-checking bench for the positional list unit
// drives list requests on the s_ stream and checks each m_ result against an in-bench list
// model; depends on pli_pkg and positional_list_insert_delete_unit
module tb_positional_list_insert_delete_unit;
    import pli_pkg::*;

    localparam int LIST_DEPTH   = DEPTH_DEF;
    localparam int MAX_GAP      = 12;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1100;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] read_value;
        logic [POS_W-1:0]         entry_count;
    } list_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // fields from bit 0: opcode[2:0], position[11:3], value[43:12], zero pad
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // fields from bit 0: status[1:0], read_value[33:2], entry_count[42:34], zero pad
    logic [47:0] m_tdata;

    // list model state, updated as each request is accepted
    logic signed [DATA_W-1:0] model_entries [LIST_DEPTH];
    int                       held_count;
    list_result_t             expected_results_q [$];

    int error_count = 0;
    int idle_cycles = 0;
    bit tx_idle_on  = 1'b1;
    bit rx_idle_on  = 1'b1;

    positional_list_insert_delete_unit #(
        .DEPTH(LIST_DEPTH)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #10 aclk = ~aclk;

    // open a gap at 0-based index idx and write val there
    function automatic void open_slot(int idx, logic signed [DATA_W-1:0] val);
        for (int k = held_count; k > idx; k--) begin
            model_entries[k] = model_entries[k-1];
        end
        model_entries[idx] = val;
        held_count++;
    endfunction

    // close the entry at 0-based index idx
    function automatic void close_slot(int idx);
        for (int k = idx; k + 1 < held_count; k++) begin
            model_entries[k] = model_entries[k+1];
        end
        held_count--;
    endfunction

    // apply one request to the list model and return the result it yields
    function automatic list_result_t apply_list_op(op_t op, logic [POS_W-1:0] pos,
                                                   logic signed [DATA_W-1:0] val);
        list_result_t r;
        bit           full;
        bit           empty;
        bit           pos_ok;
        r.status     = ST_OK;
        r.read_value = '0;
        full   = (held_count >= LIST_DEPTH);
        empty  = (held_count == 0);
        pos_ok = (int'(pos) >= 1) && (int'(pos) <= held_count);
        case (op)
            OP_APPEND_TAIL: begin
                if (full) r.status = ST_FULL;
                else open_slot(held_count, val);
            end
            OP_REMOVE_TAIL: begin
                if (empty) r.status = ST_EMPTY;
                else held_count--;
            end
            OP_INSERT_HEAD: begin
                if (full) r.status = ST_FULL;
                else open_slot(0, val);
            end
            OP_REMOVE_HEAD: begin
                if (empty) r.status = ST_EMPTY;
                else close_slot(0);
            end
            // full is reported ahead of a bad position
            OP_INSERT_AT: begin
                if (full) r.status = ST_FULL;
                else if (!pos_ok) r.status = ST_RANGE;
                else open_slot(int'(pos) - 1, val);
            end
            OP_REMOVE_AT: begin
                if (empty) r.status = ST_EMPTY;
                else if (!pos_ok) r.status = ST_RANGE;
                else close_slot(int'(pos) - 1);
            end
            OP_READ: begin
                if (empty) r.status = ST_EMPTY;
                else if (!pos_ok) r.status = ST_RANGE;
                else r.read_value = model_entries[int'(pos) - 1];
            end
            default: begin
            end
        endcase
        r.entry_count = POS_W'(held_count);
        return r;
    endfunction

    // present one request after a random gap and wait for it to be taken
    task automatic send_request(op_t op, logic [POS_W-1:0] pos, logic signed [DATA_W-1:0] val);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, val, pos, op};
        do @(posedge aclk); while (!s_tready);
        expected_results_q.push_back(apply_list_op(op, pos, val));
    endtask

    // every removal and read on an empty list, plus an insert at that cannot land
    task automatic test_empty_list();
        send_request(OP_REMOVE_TAIL, 9'd0, 32'sd0);
        send_request(OP_REMOVE_HEAD, 9'd1, 32'sd0);
        send_request(OP_REMOVE_AT, 9'd1, 32'sd0);
        send_request(OP_READ, 9'd1, 32'sd0);
        send_request(OP_INSERT_AT, 9'd1, 32'sd5);
    endtask

    // value extremes, position edges and the unused opcode on a short list
    task automatic test_positions_and_extremes();
        send_request(OP_APPEND_TAIL, 9'd0, 32'sh7fff_ffff);
        send_request(OP_INSERT_HEAD, 9'd0, 32'sh8000_0000);
        send_request(OP_INSERT_AT, 9'd0, 32'sd7);
        send_request(OP_INSERT_AT, 9'd3, 32'sd7);
        send_request(OP_INSERT_AT, 9'd2, 32'sd0);
        send_request(OP_INSERT_AT, 9'd1, -32'sd1);
        send_request(OP_READ, 9'd0, 32'sd0);
        send_request(OP_READ, 9'd256, 32'sd0);
        send_request(OP_READ, 9'd5, 32'sd0);
        send_request(OP_READ, 9'd4, 32'sd0);
        send_request(OP_NOP, 9'd511, 32'sd0);
        send_request(OP_REMOVE_AT, 9'd0, 32'sd0);
        send_request(OP_REMOVE_AT, 9'd5, 32'sd0);
        send_request(OP_REMOVE_AT, 9'd2, 32'sd0);
        send_request(OP_REMOVE_HEAD, 9'd0, 32'sd0);
        send_request(OP_REMOVE_TAIL, 9'd0, 32'sd0);
    endtask

    // fill to capacity with a mix of inserts, then hit the full list, read and remove the last entry and insert again
    task automatic test_full_list();
        int n;
        n = 0;
        while (held_count < LIST_DEPTH) begin
            case (n % 3)
                0: send_request(OP_APPEND_TAIL, 9'd0, $urandom);
                1: send_request(OP_INSERT_HEAD, 9'd0, $urandom);
                default: send_request(OP_INSERT_AT, POS_W'($urandom_range(1, held_count)),
                                      $urandom);
            endcase
            n++;
        end
        send_request(OP_APPEND_TAIL, 9'd0, 32'sd1);
        send_request(OP_INSERT_HEAD, 9'd0, 32'sd2);
        send_request(OP_INSERT_AT, 9'd0, 32'sd3);
        send_request(OP_READ, POS_W'(LIST_DEPTH), 32'sd0);
        send_request(OP_REMOVE_AT, POS_W'(LIST_DEPTH), 32'sd0);
        send_request(OP_INSERT_AT, POS_W'(LIST_DEPTH - 1), 32'sh7fff_ffff);
    endtask

    // random bursts that lean toward growing, shrinking or holding the list size
    task automatic test_random_traffic(int n_items);
        int                       sent;
        int                       burst_len;
        int                       mode;
        int                       roll;
        op_t                      op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
        sent = 0;
        while (sent < n_items) begin
            burst_len  = $urandom_range(20, 80);
            mode       = $urandom_range(0, 2);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < burst_len && sent < n_items; i++) begin
                roll = $urandom_range(0, 99);
                if (roll >= 95) begin
                    op = OP_NOP;
                end else if ((mode == 0 && roll < 55) || (mode == 1 && roll < 20) ||
                             (mode == 2 && roll < 35)) begin
                    case ($urandom_range(0, 2))
                        0: op = OP_APPEND_TAIL;
                        1: op = OP_INSERT_HEAD;
                        default: op = OP_INSERT_AT;
                    endcase
                end else if ((mode == 0 && roll < 80) || (mode == 1 && roll < 45) ||
                             (mode == 2 && roll < 65)) begin
                    op = OP_READ;
                end else begin
                    case ($urandom_range(0, 2))
                        0: op = OP_REMOVE_TAIL;
                        1: op = OP_REMOVE_HEAD;
                        default: op = OP_REMOVE_AT;
                    endcase
                end
                // positions mostly valid, some just past the end, zero, or anywhere
                roll = $urandom_range(0, 99);
                if (roll < 75) pos = POS_W'($urandom_range(1, (held_count > 0) ? held_count : 1));
                else if (roll < 85) pos = POS_W'(held_count + 1);
                else if (roll < 92) pos = '0;
                else pos = POS_W'($urandom_range(0, 256));
                // values: occasional corner values, otherwise full-width random
                case ($urandom_range(0, 19))
                    0: val = 32'sh8000_0000;
                    1: val = 32'sh7fff_ffff;
                    2: val = 32'sd0;
                    3: val = -32'sd1;
                    default: val = $urandom;
                endcase
                send_request(op, pos, val);
                sent++;
            end
        end
    endtask

    // main sequence
    initial begin
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        held_count = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_list();
        test_positions_and_extremes();
        test_full_list();
        test_random_traffic(RANDOM_ITEMS);
        s_tvalid <= 1'b0;
        while (expected_results_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // result side: random stall before each result is taken
    initial begin
        int wait_cycles;
        m_tready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            wait_cycles = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // compare each accepted result with the oldest expected one
    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results_q.size() == 0) begin
                $error("result with no request outstanding: m_tdata=%h", m_tdata);
                error_count++;
            end else begin
                want = expected_results_q.pop_front();
                if (m_tdata[1:0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
                    error_count++;
                end
                if (m_tdata[33:2] !== want.read_value) begin
                    $error("read_value: expected %0d, got %0d", want.read_value,
                           $signed(m_tdata[33:2]));
                    error_count++;
                end
                if (m_tdata[42:34] !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d", want.entry_count,
                           m_tdata[42:34]);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
